// ----- hdl/suffix_scan_engine_core_defines.svh -----
// assertion macros shared by the suffix scan engine checker
`ifndef SUFFIX_SCAN_ENGINE_CORE_DEFINES_SVH
`define SUFFIX_SCAN_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sse_pkg.sv -----
// types and constants of the suffix scan engine
`default_nettype none

package sse_pkg;

    // port payload and register port widths
    localparam int ELEM_W = 64;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // configuration field widths
    localparam int OP_W = 3;
    localparam int TT_W = 4;
    localparam int RW_W = 9;
    localparam int SL_W = 16;
    localparam int GC_W = 16;

    // configuration reset values
    localparam logic [OP_W-1:0] RST_OPERATION   = 3'd0;
    localparam logic [TT_W-1:0] RST_TRUTH_TABLE = 4'd1;
    localparam logic [RW_W-1:0] RST_ROW_WIDTH   = 9'd1;
    localparam logic [SL_W-1:0] RST_SCAN_LENGTH = 16'd1;
    localparam logic [GC_W-1:0] RST_GROUP_COUNT = 16'd1;

    // scan operations
    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_MAX     = 3'd3,
        OP_MIN     = 3'd4,
        OP_BITWISE = 3'd5
    } t_op;

    // register index, taken from paddr word address
    typedef enum logic [2:0] {
        REG_OPERATION   = 3'd0,
        REG_TRUTH_TABLE = 3'd1,
        REG_ROW_WIDTH   = 3'd2,
        REG_SCAN_LENGTH = 3'd3,
        REG_GROUP_COUNT = 3'd4
    } t_reg_idx;

endpackage

`default_nettype wire

// ----- hdl/sse_if.sv -----
// element and result stream interfaces of the suffix scan engine
`default_nettype none

interface sse_elem_if;
    logic                        valid;
    logic                        ready;
    logic [sse_pkg::ELEM_W-1:0]  element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface sse_res_if;
    logic                        valid;
    logic                        ready;
    logic [sse_pkg::ELEM_W-1:0]  result;
    logic                        overflow;
    logic                        done_res;

    modport source (output valid, output result, output overflow, output done_res, input ready);
    modport sink   (input valid, input result, input overflow, input done_res, output ready);
endinterface

`default_nettype wire

// ----- hdl/suffix_scan_engine_core.sv -----
// suffix scan engine top level: counters, accumulator ram, scan datapath, register port
//
//   port     kind        direction  content
//   i_elem   valid/ready in         element, one beat per array element (last first)
//   o_res    valid/ready out        result, overflow, done_res, one beat per element
//   apb      psel/penable in/out    operation, truth_table, row_width, scan_length,
//                                   group_count at byte address 4*index
//
// one element per cycle when nothing stalls; a result passes stage 1, stages 2 to 5
//   and the output register; multiply: an element waits while an earlier element of
//   its column is in stages 1 to 5 (accumulator write as it leaves stage 5), so
//   row_width n below 6 slows the element rate
// other operations write the accumulator ram as the element leaves stage 1, the
//   register ahead of the ram output covers back-to-back use of one column
// i_rst_n clears the registers and counters, the ram is not cleared
// a stalled o_res fills the pipeline stages before i_elem.ready drops
`default_nettype none

module suffix_scan_engine_core #(
    parameter int MAX_ROW_WIDTH = 256,
    parameter int DATA_WIDTH    = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sse_elem_if.sink                    i_elem,
    sse_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sse_pkg::APB_AW-1:0]  paddr,
    input  logic [sse_pkg::APB_DW-1:0]  pwdata,
    output logic [sse_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int DW    = DATA_WIDTH;
    localparam int EW    = sse_pkg::ELEM_W;
    localparam int PW    = sse_pkg::APB_DW;
    localparam int COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int CMP_W = COL_W + 1;
    localparam int RWC_W = (CMP_W > sse_pkg::RW_W) ? CMP_W : sse_pkg::RW_W;
    localparam int SL_W  = sse_pkg::SL_W;
    localparam int GC_W  = sse_pkg::GC_W;
    localparam int LO_W  = (DW + 1) / 2;
    localparam int HI_W  = DW - LO_W;

    // configuration registers
    logic [sse_pkg::OP_W-1:0] r_operation;
    logic [sse_pkg::TT_W-1:0] r_truth_table;
    logic [sse_pkg::RW_W-1:0] r_row_width;
    logic [SL_W-1:0]          r_scan_length;
    logic [GC_W-1:0]          r_group_count;
    logic                     w_cfg_wr;

    // position counters
    logic [COL_W-1:0] r_col_idx;
    logic [SL_W-1:0]  r_row_idx;
    logic [GC_W-1:0]  r_grp_idx;
    logic [RWC_W-1:0] w_rw_wide;
    logic [RWC_W-1:0] w_rw_eff;
    logic [SL_W-1:0]  w_sl_eff;
    logic [GC_W-1:0]  w_gc_eff;
    logic             w_col_last;
    logic             w_row_last;
    logic             w_grp_last;

    // handshake and hazard
    logic       w_mul_mode;
    logic       w_hazard;
    logic       w_accept;
    logic [6:1] w_take;

    // stage 1: element taken, accumulator read in flight
    logic             r_s1_vld;
    logic [DW-1:0]    r_s1_x;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_first;
    logic             r_s1_done;
    logic [DW-1:0]    w_rdata;
    logic             w_fwd_hit;
    logic [DW-1:0]    w_y;
    logic [DW-1:0]    w_sum;
    logic [DW-1:0]    w_diff;
    logic [DW-1:0]    w_s1_res;
    logic             w_s1_ovf;

    // last accumulator write, covers a read taken at the same edge
    logic             r_fwd_vld;
    logic [COL_W-1:0] r_fwd_col;
    logic [DW-1:0]    r_fwd_val;

    // stages 2 to 5: carried fields
    logic [5:2]       r_vld;
    logic [5:2]       r_done;
    logic [5:2]       r_mul;
    logic [5:2]       r_ovf;
    logic [5:2]       r_neg;
    logic [COL_W-1:0] r_col [2:5];
    logic [DW-1:0]    r_res [2:5];

    // multiplier data
    logic [DW-1:0]       r_ma;
    logic [DW-1:0]       r_mb;
    logic [2*LO_W-1:0]   r_p0;
    logic [DW-1:0]       r_p1;
    logic [DW-1:0]       r_p2;
    logic [2*HI_W-1:0]   r_p3;
    logic [DW:0]         r_mid;
    logic [2*LO_W-1:0]   r_p0q;
    logic [2*HI_W-1:0]   r_p3q;
    logic [2*DW-1:0]     r_prod;
    logic [DW:0]         w_upper;
    logic                w_mul_ovf;
    logic [DW-1:0]       w_mul_res;
    logic [DW-1:0]       w_s5_res;
    logic                w_s5_ovf;

    // output register
    logic          r_out_vld;
    logic [DW-1:0] r_out_res;
    logic          r_out_ovf;
    logic          r_out_done;

    // accumulator write port
    logic             w_we;
    logic [COL_W-1:0] w_waddr;
    logic [DW-1:0]    w_wdata;

    // register port write and read
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation   <= sse_pkg::RST_OPERATION;
            r_truth_table <= sse_pkg::RST_TRUTH_TABLE;
            r_row_width   <= sse_pkg::RST_ROW_WIDTH;
            r_scan_length <= sse_pkg::RST_SCAN_LENGTH;
            r_group_count <= sse_pkg::RST_GROUP_COUNT;
        end else if (w_cfg_wr) begin
            case (sse_pkg::t_reg_idx'(paddr[4:2]))
                sse_pkg::REG_OPERATION:   r_operation   <= pwdata[sse_pkg::OP_W-1:0];
                sse_pkg::REG_TRUTH_TABLE: r_truth_table <= pwdata[sse_pkg::TT_W-1:0];
                sse_pkg::REG_ROW_WIDTH:   r_row_width   <= pwdata[sse_pkg::RW_W-1:0];
                sse_pkg::REG_SCAN_LENGTH: r_scan_length <= pwdata[SL_W-1:0];
                sse_pkg::REG_GROUP_COUNT: r_group_count <= pwdata[GC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sse_pkg::t_reg_idx'(paddr[4:2]))
            sse_pkg::REG_OPERATION:   prdata = PW'(r_operation);
            sse_pkg::REG_TRUTH_TABLE: prdata = PW'(r_truth_table);
            sse_pkg::REG_ROW_WIDTH:   prdata = PW'(r_row_width);
            sse_pkg::REG_SCAN_LENGTH: prdata = PW'(r_scan_length);
            sse_pkg::REG_GROUP_COUNT: prdata = PW'(r_group_count);
            default:                  prdata = '0;
        endcase
    end

    // effective limits: zero reads as one, row width saturates at the ram depth
    always_comb begin
        w_rw_wide = RWC_W'(r_row_width);
        if (w_rw_wide == '0) begin
            w_rw_eff = RWC_W'(1);
        end else if (w_rw_wide > RWC_W'(MAX_ROW_WIDTH)) begin
            w_rw_eff = RWC_W'(MAX_ROW_WIDTH);
        end else begin
            w_rw_eff = w_rw_wide;
        end
        w_sl_eff   = (r_scan_length == '0) ? SL_W'(1) : r_scan_length;
        w_gc_eff   = (r_group_count == '0) ? GC_W'(1) : r_group_count;
        w_col_last = RWC_W'({1'b0, r_col_idx} + CMP_W'(1)) >= w_rw_eff;
        w_row_last = ({1'b0, r_row_idx} + (SL_W + 1)'(1)) >= {1'b0, w_sl_eff};
        w_grp_last = ({1'b0, r_grp_idx} + (GC_W + 1)'(1)) >= {1'b0, w_gc_eff};
    end

    // elastic stage advance, each stage moves when the next has room
    always_comb begin
        w_take[6] = !r_out_vld || o_res.ready;
        for (int k = 5; k >= 2; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
        w_take[1] = !r_s1_vld || w_take[2];
    end

    // multiply interlock: hold an element while its column is still in flight
    assign w_mul_mode = (r_operation == sse_pkg::OP_MUL);

    always_comb begin
        w_hazard = r_s1_vld && (r_s1_col == r_col_idx);
        for (int k = 2; k <= 5; k++) begin
            w_hazard = w_hazard || (r_vld[k] && (r_col[k] == r_col_idx));
        end
        w_hazard = w_hazard && w_mul_mode;
    end

    assign i_elem.ready = w_take[1] && !w_hazard;
    assign w_accept     = i_elem.valid && i_elem.ready;

    // column, row and group counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_idx <= '0;
            r_row_idx <= '0;
            r_grp_idx <= '0;
        end else if (w_accept) begin
            if (w_col_last) begin
                r_col_idx <= '0;
                if (w_row_last) begin
                    r_row_idx <= '0;
                    r_grp_idx <= w_grp_last ? '0 : r_grp_idx + GC_W'(1);
                end else begin
                    r_row_idx <= r_row_idx + SL_W'(1);
                end
            end else begin
                r_col_idx <= r_col_idx + COL_W'(1);
            end
        end
    end

    // accumulator ram, read at the taken element's column
    sse_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ROW_WIDTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (r_col_idx),
        .o_rdata (w_rdata)
    );

    // write back early for operations other than multiply, after the multiplier otherwise
    always_comb begin
        if (w_mul_mode) begin
            w_we    = r_vld[5] && w_take[6];
            w_waddr = r_col[5];
            w_wdata = w_s5_res;
        end else begin
            w_we    = r_s1_vld && w_take[2];
            w_waddr = r_s1_col;
            w_wdata = w_s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (w_we) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_fwd_col <= w_waddr;
            r_fwd_val <= w_wdata;
        end
    end

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_take[1]) begin
            r_s1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_x     <= i_elem.element[DW-1:0];
            r_s1_col   <= r_col_idx;
            r_s1_first <= (r_row_idx == '0);
            r_s1_done  <= w_col_last && w_row_last && w_grp_last;
        end
    end

    // stage 1 datapath: operations other than multiply
    assign w_fwd_hit = r_fwd_vld && (r_fwd_col == r_s1_col);
    assign w_y       = w_fwd_hit ? r_fwd_val : w_rdata;
    assign w_sum     = r_s1_x + w_y;
    assign w_diff    = r_s1_x - w_y;

    always_comb begin
        w_s1_ovf = 1'b0;
        case (sse_pkg::t_op'(r_operation))
            sse_pkg::OP_ADD: begin
                w_s1_res = w_sum;
                w_s1_ovf = (r_s1_x[DW-1] == w_y[DW-1]) && (w_sum[DW-1] != r_s1_x[DW-1]);
            end
            sse_pkg::OP_SUB: begin
                w_s1_res = w_diff;
                w_s1_ovf = (r_s1_x[DW-1] != w_y[DW-1]) && (w_diff[DW-1] != r_s1_x[DW-1]);
            end
            sse_pkg::OP_MUL: begin
                w_s1_res = r_s1_x;
            end
            sse_pkg::OP_MAX: begin
                w_s1_res = ($signed(r_s1_x) > $signed(w_y)) ? r_s1_x : w_y;
            end
            sse_pkg::OP_MIN: begin
                w_s1_res = ($signed(r_s1_x) < $signed(w_y)) ? r_s1_x : w_y;
            end
            sse_pkg::OP_BITWISE: begin
                w_s1_res = ({DW{r_truth_table[3]}} & ~r_s1_x & ~w_y)
                         | ({DW{r_truth_table[2]}} & ~r_s1_x &  w_y)
                         | ({DW{r_truth_table[1]}} &  r_s1_x & ~w_y)
                         | ({DW{r_truth_table[0]}} &  r_s1_x &  w_y);
            end
            default: begin
                w_s1_res = r_s1_x;
            end
        endcase
        // first row of a group loads the element as is
        if (r_s1_first) begin
            w_s1_res = r_s1_x;
            w_s1_ovf = 1'b0;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_take[2]) begin
                r_vld[2] <= r_s1_vld;
            end
            for (int k = 3; k <= 5; k++) begin
                if (w_take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage payloads and multiplier steps
    always_ff @(posedge i_clk) begin
        if (w_take[2]) begin
            r_col[2]  <= r_s1_col;
            r_done[2] <= r_s1_done;
            r_mul[2]  <= w_mul_mode && !r_s1_first;
            r_res[2]  <= w_s1_res;
            r_ovf[2]  <= w_s1_ovf;
            r_neg[2]  <= r_s1_x[DW-1] ^ w_y[DW-1];
            r_ma      <= r_s1_x[DW-1] ? DW'(0) - r_s1_x : r_s1_x;
            r_mb      <= w_y[DW-1] ? DW'(0) - w_y : w_y;
        end
        for (int k = 3; k <= 5; k++) begin
            if (w_take[k]) begin
                r_col[k]  <= r_col[k-1];
                r_done[k] <= r_done[k-1];
                r_mul[k]  <= r_mul[k-1];
                r_res[k]  <= r_res[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_neg[k]  <= r_neg[k-1];
            end
        end
        // partial products of the magnitudes
        if (w_take[3]) begin
            r_p0 <= (2*LO_W)'(r_ma[LO_W-1:0]) * (2*LO_W)'(r_mb[LO_W-1:0]);
            r_p1 <= DW'(r_ma[LO_W-1:0]) * DW'(r_mb[DW-1:LO_W]);
            r_p2 <= DW'(r_ma[DW-1:LO_W]) * DW'(r_mb[LO_W-1:0]);
            r_p3 <= (2*HI_W)'(r_ma[DW-1:LO_W]) * (2*HI_W)'(r_mb[DW-1:LO_W]);
        end
        // cross terms
        if (w_take[4]) begin
            r_mid <= (DW + 1)'(r_p1) + (DW + 1)'(r_p2);
            r_p0q <= r_p0;
            r_p3q <= r_p3;
        end
        // full magnitude product
        if (w_take[5]) begin
            r_prod <= {r_p3q, r_p0q} + ((2*DW)'(r_mid) << LO_W);
        end
    end

    // stage 5: sign and overflow of the product
    assign w_upper   = r_prod[2*DW-1:DW-1];
    assign w_mul_ovf = (w_upper != '0)
                     && !(r_neg[5] && (w_upper == (DW + 1)'(1)) && (r_prod[DW-2:0] == '0));
    assign w_mul_res = r_neg[5] ? DW'(0) - r_prod[DW-1:0] : r_prod[DW-1:0];
    assign w_s5_res  = r_mul[5] ? w_mul_res : r_res[5];
    assign w_s5_ovf  = r_mul[5] ? w_mul_ovf : r_ovf[5];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take[6]) begin
            r_out_vld <= r_vld[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[6]) begin
            r_out_res  <= w_s5_res;
            r_out_ovf  <= w_s5_ovf;
            r_out_done <= r_done[5];
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.result   = EW'($signed(r_out_res));
    assign o_res.overflow = r_out_ovf;
    assign o_res.done_res = r_out_done;

endmodule

`default_nettype wire

// ----- hdl/sse_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module sse_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/sse_checker.sv -----
// port-level checker of the suffix scan engine and its bind
`default_nettype none
`include "suffix_scan_engine_core_defines.svh"

module sse_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_elem_valid,
    input wire logic                        i_elem_ready,
    input wire logic                        i_res_valid,
    input wire logic                        i_res_ready,
    input wire logic [sse_pkg::ELEM_W-1:0]  i_result,
    input wire logic                        i_overflow,
    input wire logic                        i_done_res,
    input wire logic                        i_psel,
    input wire logic                        i_penable,
    input wire logic                        i_pwrite,
    input wire logic [sse_pkg::APB_AW-1:0]  i_paddr,
    input wire logic [sse_pkg::APB_DW-1:0]  i_pwdata,
    input wire logic [sse_pkg::APB_DW-1:0]  i_prdata
);

    localparam int PW = sse_pkg::APB_DW;

    logic [3:0]               r_cnt;
    logic [sse_pkg::OP_W-1:0] r_op;
    logic                     w_in_beat;
    logic                     w_out_beat;

    assign w_in_beat  = i_elem_valid && i_elem_ready;
    assign w_out_beat = i_res_valid && i_res_ready;

    // elements taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 4'(w_in_beat) - 4'(w_out_beat);
        end
    end

    // shadow of the operation register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= sse_pkg::RST_OPERATION;
        end else if (i_psel && i_penable && i_pwrite
                     && (i_paddr[4:2] == sse_pkg::REG_OPERATION)) begin
            r_op <= i_pwdata[sse_pkg::OP_W-1:0];
        end
    end

    `SSE_ASSERT_NEXT(a_res_valid_hold, i_res_valid && !i_res_ready, i_res_valid, "result beat dropped under stall")
    `SSE_ASSERT_NEXT(a_res_stable, i_res_valid && !i_res_ready, $stable(i_result) && $stable(i_overflow) && $stable(i_done_res), "result beat changed under stall")
    `SSE_ASSERT_NOW(a_no_extra_beat, w_out_beat, r_cnt != 4'd0, "result beat without an element taken")
    `SSE_ASSERT_NOW(a_op_readback, i_psel && !i_pwrite && (i_paddr[4:2] == sse_pkg::REG_OPERATION), i_prdata == PW'(r_op), "operation readback differs from last write")

endmodule

bind suffix_scan_engine_core sse_checker u_sse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_elem_valid (i_elem.valid),
    .i_elem_ready (i_elem.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_result     (o_res.result),
    .i_overflow   (o_res.overflow),
    .i_done_res   (o_res.done_res),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata),
    .i_prdata     (prdata)
);

`default_nettype wire

// ----- tb/sv/suffix_scan_engine_core_tb.sv -----
`timescale 1ns / 1ps
// suffix scan engine testbench: directed table, then randomized register phases, all beats predicted
module suffix_scan_engine_core_tb;
    import sse_pkg::*;

    localparam int MAX_COLS     = 256;
    localparam int ITEM_GOAL    = 1500;
    localparam int STALL_LIMIT  = 2000;
    localparam int DIR_LEN      = 41;

    // operation codes beyond the package enum act as pass-through
    localparam logic [OP_W-1:0] OP_THRU_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_THRU_HI = 3'd7;

    localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_3    = 64'hFFFF_FFFF_FFFF_FFFD;
    localparam logic [63:0] NIBBLE_A = 64'h0F0F_0F0F_0F0F_0F0F;
    localparam logic [63:0] NIBBLE_B = 64'hF0F0_F0F0_F0F0_F0F0;

    typedef struct packed {
        logic [63:0] result;
        logic        overflow;
        logic        done_res;
    } t_scan_beat;

    typedef enum logic {ROW_ELEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_reg_idx   reg_idx;
        logic [63:0] value;
        logic       typed;
        t_scan_beat want;
    } t_dir_row;

    // directed stimulus: register writes and elements, typed results where obvious
    t_dir_row dir_rows [DIR_LEN] = '{
        '{ROW_ELEM, REG_OPERATION,   MAX_POS,          1'b1, '{MAX_POS,  1'b0, 1'b1}},
        '{ROW_ELEM, REG_OPERATION,   MIN_NEG,          1'b1, '{MIN_NEG,  1'b0, 1'b1}},
        '{ROW_CFG,  REG_SCAN_LENGTH, 64'd2,            1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'd1,            1'b1, '{64'd1,    1'b0, 1'b0}},
        '{ROW_ELEM, REG_OPERATION,   MAX_POS,          1'b1, '{MIN_NEG,  1'b1, 1'b1}},
        '{ROW_ELEM, REG_OPERATION,   ALL_ONES,         1'b1, '{ALL_ONES, 1'b0, 1'b0}},
        '{ROW_ELEM, REG_OPERATION,   MIN_NEG,          1'b1, '{MAX_POS,  1'b1, 1'b1}},
        '{ROW_CFG,  REG_OPERATION,   64'(OP_SUB),      1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'd1,            1'b1, '{64'd1,    1'b0, 1'b0}},
        '{ROW_ELEM, REG_OPERATION,   MIN_NEG,          1'b1, '{MAX_POS,  1'b1, 1'b1}},
        '{ROW_CFG,  REG_OPERATION,   64'(OP_MUL),      1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   MIN_NEG,          1'b1, '{MIN_NEG,  1'b0, 1'b0}},
        '{ROW_ELEM, REG_OPERATION,   ALL_ONES,         1'b1, '{MIN_NEG,  1'b1, 1'b1}},
        '{ROW_CFG,  REG_OPERATION,   64'(OP_MAX),      1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'd5,            1'b1, '{64'd5,    1'b0, 1'b0}},
        '{ROW_ELEM, REG_OPERATION,   NEG_3,            1'b1, '{64'd5,    1'b0, 1'b1}},
        '{ROW_CFG,  REG_OPERATION,   64'(OP_MIN),      1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'd5,            1'b1, '{64'd5,    1'b0, 1'b0}},
        '{ROW_ELEM, REG_OPERATION,   NEG_3,            1'b1, '{NEG_3,    1'b0, 1'b1}},
        '{ROW_CFG,  REG_TRUTH_TABLE, 64'h6,            1'b0, '0},
        '{ROW_CFG,  REG_OPERATION,   64'(OP_BITWISE),  1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   NIBBLE_A,         1'b1, '{NIBBLE_A, 1'b0, 1'b0}},
        '{ROW_ELEM, REG_OPERATION,   ALL_ONES,         1'b1, '{NIBBLE_B, 1'b0, 1'b1}},
        '{ROW_CFG,  REG_OPERATION,   64'(OP_THRU_HI),  1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'd3,            1'b1, '{64'd3,    1'b0, 1'b0}},
        '{ROW_ELEM, REG_OPERATION,   64'd9,            1'b1, '{64'd9,    1'b0, 1'b1}},
        '{ROW_CFG,  REG_ROW_WIDTH,   64'd0,            1'b0, '0},
        '{ROW_CFG,  REG_SCAN_LENGTH, 64'd0,            1'b0, '0},
        '{ROW_CFG,  REG_GROUP_COUNT, 64'd0,            1'b0, '0},
        '{ROW_CFG,  REG_OPERATION,   64'(OP_ADD),      1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'd42,           1'b1, '{64'd42,   1'b0, 1'b1}},
        '{ROW_CFG,  REG_ROW_WIDTH,   64'd2,            1'b0, '0},
        '{ROW_CFG,  REG_SCAN_LENGTH, 64'd3,            1'b0, '0},
        '{ROW_CFG,  REG_GROUP_COUNT, 64'd2,            1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'hFEDC_BA98_7654_3210, 1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'h7000_0000_0000_0000, 1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   64'h7000_0000_0000_0001, 1'b0, '0},
        // shrink the scan length while the row counter is already past it
        '{ROW_CFG,  REG_SCAN_LENGTH, 64'd2,            1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   MIN_NEG,          1'b0, '0},
        '{ROW_ELEM, REG_OPERATION,   MAX_POS,          1'b0, '0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    sse_elem_if elem_bus();
    sse_res_if  res_bus();

    suffix_scan_engine_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // scan predictor state: register copies, column accumulators, position counters
    logic [OP_W-1:0]     cfg_op;
    logic [TT_W-1:0]     cfg_tt;
    logic [RW_W-1:0]     cfg_rw;
    logic [SL_W-1:0]     cfg_sl;
    logic [GC_W-1:0]     cfg_gc;
    logic [63:0]         col_acc [MAX_COLS];
    logic [MAX_COLS-1:0] col_loaded;
    int unsigned         col_idx;
    int unsigned         row_idx;
    int unsigned         grp_idx;

    t_scan_beat          scan_expect [$];
    t_scan_beat          head_beat;

    int unsigned n_fail;
    int unsigned n_sent;
    int unsigned n_checked;
    int unsigned n_cfg_writes;
    int unsigned n_phases;
    int unsigned n_ovf_beats;
    int unsigned n_done_beats;
    int unsigned quiet_cycles;
    int unsigned rx_hold;
    bit          quiet_tail;
    bit          tx_gappy;
    bit          rx_gappy;

    // effective array shape after zero and saturation rules
    function automatic void eff_dims(output int unsigned rw, output int unsigned sl,
                                     output int unsigned gc);
        rw = (cfg_rw == 0) ? 1 : ((cfg_rw > MAX_COLS) ? MAX_COLS : int'(cfg_rw));
        sl = (cfg_sl == 0) ? 1 : int'(cfg_sl);
        gc = (cfg_gc == 0) ? 1 : int'(cfg_gc);
    endfunction

    // next scan beat for element x; advances accumulators and counters
    function automatic t_scan_beat scan_predict(input logic [63:0] x);
        int unsigned       rw;
        int unsigned       sl;
        int unsigned       gc;
        int unsigned       col;
        logic [63:0]       y;
        logic [63:0]       r;
        logic signed [127:0] xw;
        logic signed [127:0] yw;
        logic signed [127:0] prod;
        t_scan_beat        beat;

        eff_dims(rw, sl, gc);
        col  = (col_idx < MAX_COLS) ? col_idx : 0;
        y    = col_acc[col];
        beat = '0;
        if (row_idx == 0) begin
            r = x;
        end else begin
            if (!col_loaded[col]) begin
                $error("stimulus reads column %0d before it was loaded", col);
                n_fail++;
            end
            case (cfg_op)
                OP_ADD: begin
                    r = x + y;
                    beat.overflow = (x[63] == y[63]) && (r[63] != x[63]);
                end
                OP_SUB: begin
                    r = x - y;
                    beat.overflow = (x[63] != y[63]) && (r[63] != x[63]);
                end
                OP_MUL: begin
                    xw = $signed(x);
                    yw = $signed(y);
                    prod = xw * yw;
                    r = prod[63:0];
                    beat.overflow = !((&prod[127:63]) || (~|prod[127:63]));
                end
                OP_MAX: r = ($signed(x) > $signed(y)) ? x : y;
                OP_MIN: r = ($signed(x) < $signed(y)) ? x : y;
                OP_BITWISE: begin
                    r = ({64{cfg_tt[3]}} & ~x & ~y) | ({64{cfg_tt[2]}} & ~x & y)
                      | ({64{cfg_tt[1]}} & x & ~y) | ({64{cfg_tt[0]}} & x & y);
                end
                default: r = x;
            endcase
        end
        col_acc[col]    = r;
        col_loaded[col] = 1'b1;
        beat.result     = r;

        // column, then row, then group counter; a counter past its limit wraps
        if (col_idx + 1 >= rw) begin
            col_idx = 0;
            if (row_idx + 1 >= sl) begin
                row_idx = 0;
                if (grp_idx + 1 >= gc) begin
                    grp_idx = 0;
                    beat.done_res = 1'b1;
                end else begin
                    grp_idx++;
                end
            end else begin
                row_idx++;
            end
        end else begin
            col_idx++;
        end
        return beat;
    endfunction

    // element mix: extremes, small values that keep products in range, full-width noise
    function automatic logic [63:0] rand_element();
        logic [63:0] v;
        int          small_val;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = 64'd1;
                    2:       v = ALL_ONES;
                    3:       v = MIN_NEG;
                    default: v = MAX_POS;
                endcase
            end
            1, 2, 3, 4: begin
                small_val = int'($urandom_range(0, 200)) - 100;
                v = {{32{small_val[31]}}, small_val};
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // one element beat, with an optional idle burst ahead of it
    task automatic send_element(input logic [63:0] x, input logic typed, input t_scan_beat want);
        int unsigned gap;
        t_scan_beat  predicted;
        gap = 0;
        if (psel) begin
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        predicted = scan_predict(x);
        scan_expect.push_back(typed ? want : predicted);
        if (!quiet_tail && tx_gappy && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 10);
        if (gap != 0) begin
            elem_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        elem_bus.valid   <= 1'b1;
        elem_bus.element <= x;
        do @(posedge i_clk); while (!elem_bus.ready);
        n_sent++;
    endtask

    // stop sending and wait until every predicted beat has come back
    task automatic drain_results();
        elem_bus.valid <= 1'b0;
        while (scan_expect.size() != 0) @(posedge i_clk);
    endtask

    // register write: setup then access; psel stays high across back-to-back writes
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_OPERATION:   cfg_op = value[OP_W-1:0];
            REG_TRUTH_TABLE: cfg_tt = value[TT_W-1:0];
            REG_ROW_WIDTH:   cfg_rw = value[RW_W-1:0];
            REG_SCAN_LENGTH: cfg_sl = value[SL_W-1:0];
            REG_GROUP_COUNT: cfg_gc = value[GC_W-1:0];
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    // result sink ready with random stall bursts
    initial begin
        res_bus.ready = 1'b1;
        rx_hold = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold != 0) begin
                rx_hold--;
                res_bus.ready <= 1'b0;
            end else if (!quiet_tail && rx_gappy && $urandom_range(0, 99) < 12) begin
                rx_hold = $urandom_range(0, 9);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // result beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (scan_expect.size() == 0) begin
                $error("result beat with nothing expected: result %h", res_bus.result);
                n_fail++;
            end else begin
                head_beat = scan_expect.pop_front();
                if (res_bus.result !== head_beat.result) begin
                    $error("result: expected %h, got %h", head_beat.result, res_bus.result);
                    n_fail++;
                end
                if (res_bus.overflow !== head_beat.overflow) begin
                    $error("overflow: expected %b, got %b", head_beat.overflow, res_bus.overflow);
                    n_fail++;
                end
                if (res_bus.done_res !== head_beat.done_res) begin
                    $error("done_res: expected %b, got %b", head_beat.done_res, res_bus.done_res);
                    n_fail++;
                end
                n_checked++;
                if (head_beat.overflow) n_ovf_beats++;
                if (head_beat.done_res) n_done_beats++;
            end
        end
    end

    // watchdog on cycles without any beat or register access
    always @(posedge i_clk) begin
        if ((elem_bus.valid && elem_bus.ready) || (res_bus.valid && res_bus.ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("suffix_scan_engine_core regression: fail");
            $finish;
        end
    end

    // main sequence: reset, directed table, column priming, random phases, tail
    initial begin
        int unsigned     rw_e;
        int unsigned     sl_e;
        int unsigned     gc_e;
        int unsigned     len;
        int unsigned     pick;
        longint unsigned span;
        logic [OP_W-1:0] op_pick;

        elem_bus.valid   = 1'b0;
        elem_bus.element = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        cfg_op  = RST_OPERATION;
        cfg_tt  = RST_TRUTH_TABLE;
        cfg_rw  = RST_ROW_WIDTH;
        cfg_sl  = RST_SCAN_LENGTH;
        cfg_gc  = RST_GROUP_COUNT;
        col_loaded = '0;
        col_idx = 0;
        row_idx = 0;
        grp_idx = 0;
        n_fail = 0;
        n_sent = 0;
        n_checked = 0;
        n_cfg_writes = 0;
        n_phases = 0;
        n_ovf_beats = 0;
        n_done_beats = 0;
        quiet_cycles = 0;
        quiet_tail = 1'b0;
        tx_gappy = 1'b1;
        rx_gappy = 1'b1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_LEN; i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_results();
                reg_write(dir_rows[i].reg_idx, dir_rows[i].value[31:0]);
            end else begin
                send_element(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // load every column once: row width above the maximum saturates, single-row groups
        drain_results();
        op_pick = OP_W'($urandom_range(OP_ADD, OP_BITWISE));
        reg_write(REG_OPERATION, 32'(op_pick));
        reg_write(REG_ROW_WIDTH, 32'h1FF);
        reg_write(REG_SCAN_LENGTH, 32'd1);
        reg_write(REG_GROUP_COUNT, 32'd1);
        for (int i = 0; i < MAX_COLS; i++) send_element(rand_element(), 1'b0, '0);

        // random phases; counters are kept across register changes
        while (n_sent < ITEM_GOAL) begin
            drain_results();
            n_phases++;
            if ($urandom_range(0, 9) == 0) begin
                op_pick = $urandom_range(0, 1) ? OP_THRU_LO : OP_THRU_HI;
            end else begin
                op_pick = OP_W'($urandom_range(OP_ADD, OP_BITWISE));
            end
            reg_write(REG_OPERATION, 32'(op_pick));
            if ($urandom_range(0, 1) == 0) reg_write(REG_TRUTH_TABLE, $urandom_range(0, 15));
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       pick = 0;
                    1:       pick = $urandom_range(0, 1) ? MAX_COLS : $urandom_range(257, 511);
                    2, 3:    pick = $urandom_range(9, 40);
                    default: pick = $urandom_range(1, 8);
                endcase
                reg_write(REG_ROW_WIDTH, pick);
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       pick = 0;
                    1:       pick = 16'hFFFF;
                    2:       pick = $urandom_range(7, 300);
                    default: pick = $urandom_range(1, 6);
                endcase
                reg_write(REG_SCAN_LENGTH, pick);
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       pick = 0;
                    1:       pick = 16'hFFFF;
                    default: pick = $urandom_range(1, 4);
                endcase
                reg_write(REG_GROUP_COUNT, pick);
            end
            tx_gappy = ($urandom_range(0, 3) != 0);
            rx_gappy = ($urandom_range(0, 3) != 0);
            quiet_tail = (n_sent >= ITEM_GOAL * 9 / 10);

            // whole arrays when the shape is small and the counters sit at the start
            eff_dims(rw_e, sl_e, gc_e);
            span = longint'(rw_e) * sl_e * gc_e;
            if (col_idx == 0 && row_idx == 0 && grp_idx == 0 && span <= 96) begin
                len = int'(span) * $urandom_range(1, 2);
            end else begin
                len = $urandom_range(8, 64);
            end
            for (int i = 0; i < len; i++) send_element(rand_element(), 1'b0, '0);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("covered %0d elements in %0d random phases with %0d register writes",
                 n_sent, n_phases, n_cfg_writes);
        $display("checked %0d result beats, %0d with overflow, %0d closing an array",
                 n_checked, n_ovf_beats, n_done_beats);
        if (n_fail == 0) begin
            $display("suffix_scan_engine_core regression: pass");
        end else begin
            $display("suffix_scan_engine_core regression: fail");
        end
        $finish;
    end

endmodule
